/* hw/rtl/ray_triangle_closest_hit_defines.svh */
// Assertion helpers for the checker of this block.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RTC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RTC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/rtc_pkg.sv */
package rtc_pkg;

	localparam int CoordW  = 32;
	localparam int EpsW    = 16;
	localparam int DistW   = 31;
	localparam int AccW    = 52;
	localparam int ProdW   = 64;
	localparam int DivNW   = 50;
	localparam int QuoW    = 31;
	localparam int RootW   = 32;
	localparam int CfgIdxW = 3;
	localparam int PcW     = 5;

	localparam logic [PcW-1:0] LastStepA = 5'd23;
	localparam logic [PcW-1:0] FirstStepB = 5'd24;
	localparam logic [PcW-1:0] LastStepB = 5'd29;

	localparam logic [CoordW-1:0] MaxQ = 32'h7FFF_FFFF;
	localparam logic [CoordW-1:0] MinQ = 32'h8000_0000;
	localparam logic [CoordW-1:0] OneQ = 32'h0001_0000;

	localparam logic [1:0] IX = 2'd0;
	localparam logic [1:0] IY = 2'd1;
	localparam logic [1:0] IZ = 2'd2;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
		REG_DIR_X, REG_DIR_Y, REG_DIR_Z, REG_EPSILON
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MACA, ST_DRAINA, ST_CHECK, ST_DIV, ST_TCHK,
		ST_MACB, ST_DRAINB, ST_SQRT, ST_FINISH
	} state_t;

	typedef enum logic [2:0] {V_D, V_E1, V_E2, V_S, V_H, V_Q, V_T, V_M} vsel_t;

	typedef enum logic [3:0] {
		WB_NONE, WB_H, WB_Q, WB_DET, WB_UN, WB_VN, WB_TN, WB_PT, WB_SQ
	} wb_t;

	typedef struct packed {
		vsel_t      va;
		logic [1:0] ia;
		vsel_t      vb;
		logic [1:0] ib;
		logic       neg;
		logic       first;
		wb_t        wb;
		logic [1:0] wi;
	} step_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
	} vec3_t;

	function automatic logic signed [CoordW-1:0] sat32(input logic signed [AccW-1:0] v);
		logic signed [CoordW-1:0] r;
		if (v[AccW-1:CoordW-1] != {(AccW-CoordW+1){v[AccW-1]}})
			r = v[AccW-1] ? MinQ : MaxQ;
		else
			r = v[CoordW-1:0];
		return r;
	endfunction

	function automatic logic signed [CoordW-1:0] comp(input vec3_t v, input logic [1:0] i);
		logic signed [CoordW-1:0] r;
		unique case (i)
			IX: r = v.x;
			IY: r = v.y;
			default: r = v.z;
		endcase
		return r;
	endfunction

	function automatic vec3_t put(input vec3_t v, input logic [1:0] i,
			input logic signed [CoordW-1:0] val);
		vec3_t r;
		r = v;
		unique case (i)
			IX: r.x = val;
			IY: r.y = val;
			default: r.z = val;
		endcase
		return r;
	endfunction

	function automatic step_t mk(input vsel_t va, input logic [1:0] ia, input vsel_t vb,
			input logic [1:0] ib, input logic neg, input logic first, input wb_t wb,
			input logic [1:0] wi);
		step_t s;
		s.va = va; s.ia = ia; s.vb = vb; s.ib = ib;
		s.neg = neg; s.first = first; s.wb = wb; s.wi = wi;
		return s;
	endfunction

	// Product schedule: h = d x e2, q = s x e1, det, u, v, t numerators,
	// then the hit point and the squared offsets.
	function automatic step_t step_f(input logic [PcW-1:0] pc);
		step_t s;
		unique case (pc)
			5'd0:  s = mk(V_D,  IY, V_E2, IZ, 1'b0, 1'b1, WB_NONE, IX);
			5'd1:  s = mk(V_D,  IZ, V_E2, IY, 1'b1, 1'b0, WB_H,    IX);
			5'd2:  s = mk(V_D,  IZ, V_E2, IX, 1'b0, 1'b1, WB_NONE, IX);
			5'd3:  s = mk(V_D,  IX, V_E2, IZ, 1'b1, 1'b0, WB_H,    IY);
			5'd4:  s = mk(V_D,  IX, V_E2, IY, 1'b0, 1'b1, WB_NONE, IX);
			5'd5:  s = mk(V_D,  IY, V_E2, IX, 1'b1, 1'b0, WB_H,    IZ);
			5'd6:  s = mk(V_S,  IY, V_E1, IZ, 1'b0, 1'b1, WB_NONE, IX);
			5'd7:  s = mk(V_S,  IZ, V_E1, IY, 1'b1, 1'b0, WB_Q,    IX);
			5'd8:  s = mk(V_S,  IZ, V_E1, IX, 1'b0, 1'b1, WB_NONE, IX);
			5'd9:  s = mk(V_S,  IX, V_E1, IZ, 1'b1, 1'b0, WB_Q,    IY);
			5'd10: s = mk(V_S,  IX, V_E1, IY, 1'b0, 1'b1, WB_NONE, IX);
			5'd11: s = mk(V_S,  IY, V_E1, IX, 1'b1, 1'b0, WB_Q,    IZ);
			5'd12: s = mk(V_E1, IX, V_H,  IX, 1'b0, 1'b1, WB_NONE, IX);
			5'd13: s = mk(V_E1, IY, V_H,  IY, 1'b0, 1'b0, WB_NONE, IX);
			5'd14: s = mk(V_E1, IZ, V_H,  IZ, 1'b0, 1'b0, WB_DET,  IX);
			5'd15: s = mk(V_S,  IX, V_H,  IX, 1'b0, 1'b1, WB_NONE, IX);
			5'd16: s = mk(V_S,  IY, V_H,  IY, 1'b0, 1'b0, WB_NONE, IX);
			5'd17: s = mk(V_S,  IZ, V_H,  IZ, 1'b0, 1'b0, WB_UN,   IX);
			5'd18: s = mk(V_D,  IX, V_Q,  IX, 1'b0, 1'b1, WB_NONE, IX);
			5'd19: s = mk(V_D,  IY, V_Q,  IY, 1'b0, 1'b0, WB_NONE, IX);
			5'd20: s = mk(V_D,  IZ, V_Q,  IZ, 1'b0, 1'b0, WB_VN,   IX);
			5'd21: s = mk(V_E2, IX, V_Q,  IX, 1'b0, 1'b1, WB_NONE, IX);
			5'd22: s = mk(V_E2, IY, V_Q,  IY, 1'b0, 1'b0, WB_NONE, IX);
			5'd23: s = mk(V_E2, IZ, V_Q,  IZ, 1'b0, 1'b0, WB_TN,   IX);
			5'd24: s = mk(V_T,  IX, V_D,  IX, 1'b0, 1'b1, WB_PT,   IX);
			5'd25: s = mk(V_T,  IX, V_D,  IY, 1'b0, 1'b1, WB_PT,   IY);
			5'd26: s = mk(V_T,  IX, V_D,  IZ, 1'b0, 1'b1, WB_PT,   IZ);
			5'd27: s = mk(V_M,  IX, V_M,  IX, 1'b0, 1'b1, WB_SQ,   IX);
			5'd28: s = mk(V_M,  IY, V_M,  IY, 1'b0, 1'b0, WB_SQ,   IY);
			5'd29: s = mk(V_M,  IZ, V_M,  IZ, 1'b0, 1'b0, WB_SQ,   IZ);
			default: s = mk(V_D, IX, V_D, IX, 1'b0, 1'b1, WB_NONE, IX);
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/rtc_if.sv */
interface rtc_tri_if;
	import rtc_pkg::*;
	logic valid;
	logic ready;
	logic signed [CoordW-1:0] a_x;
	logic signed [CoordW-1:0] a_y;
	logic signed [CoordW-1:0] a_z;
	logic signed [CoordW-1:0] b_x;
	logic signed [CoordW-1:0] b_y;
	logic signed [CoordW-1:0] b_z;
	logic signed [CoordW-1:0] c_x;
	logic signed [CoordW-1:0] c_y;
	logic signed [CoordW-1:0] c_z;
	logic last_tri;
	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_tri,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_tri,
		output ready);
endinterface

interface rtc_hit_if;
	import rtc_pkg::*;
	logic valid;
	logic ready;
	logic any_hit;
	logic signed [CoordW-1:0] hit_x;
	logic signed [CoordW-1:0] hit_y;
	logic signed [CoordW-1:0] hit_z;
	logic [DistW-1:0] hit_distance;
	modport source (output valid, any_hit, hit_x, hit_y, hit_z, hit_distance, input ready);
	modport sink (input valid, any_hit, hit_x, hit_y, hit_z, hit_distance, output ready);
endinterface

interface rtc_cfg_if;
	import rtc_pkg::*;
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [CoordW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rtc_mul.sv */
module rtc_mul (
	input  logic clk,
	input  logic signed [rtc_pkg::CoordW-1:0] a,
	input  logic signed [rtc_pkg::CoordW-1:0] b,
	output logic signed [rtc_pkg::ProdW-1:0] prod
);
	import rtc_pkg::*;

	logic signed [ProdW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= ProdW'(a) * ProdW'(b);
	end

	assign prod = prod_q;
endmodule

/* hw/rtl/rtc_div.sv */
module rtc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [rtc_pkg::DivNW-1:0] dividend,
	input  logic [rtc_pkg::CoordW-1:0] divisor,
	output logic done,
	output logic [rtc_pkg::QuoW-1:0] quot
);
	import rtc_pkg::*;

	// Quotient of (dividend << 16) / divisor, one bit per cycle, saturated.
	logic run_q, done_q;
	logic [4:0] cnt_q;
	logic [CoordW:0] rem_q;
	logic [QuoW-1:0] quo_q, nsh_q;
	logic [CoordW:0] rsh;
	logic take;
	logic ovf;

	assign ovf = dividend >= {3'b000, divisor, 15'b0};
	assign rsh = {rem_q[CoordW-1:0], nsh_q[QuoW-1]};
	assign take = rsh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= !ovf;
				done_q <= ovf;
				cnt_q <= 5'(QuoW - 1);
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[46:15]};
			nsh_q <= {dividend[14:0], 16'b0};
			quo_q <= ovf ? '1 : '0;
		end else if (run_q) begin
			rem_q <= take ? rsh - {1'b0, divisor} : rsh;
			nsh_q <= {nsh_q[QuoW-2:0], 1'b0};
			quo_q <= {quo_q[QuoW-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

/* hw/rtl/rtc_sqrt.sv */
module rtc_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [rtc_pkg::ProdW-1:0] radicand,
	output logic done,
	output logic [rtc_pkg::RootW-1:0] root
);
	import rtc_pkg::*;

	// Digit-by-digit square root, one result bit per cycle.
	logic run_q, done_q;
	logic [ProdW-1:0] n_q, res_q, bit_q;
	logic [ProdW-1:0] trial;
	logic fits;

	assign trial = res_q + bit_q;
	assign fits = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(ProdW-2){1'b0}}};
		end else if (run_q) begin
			if (fits) begin
				n_q <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[RootW-1:0];
endmodule

/* hw/rtl/ray_triangle_closest_hit.sv */
// Nearest ray-triangle hit over a streamed mesh. Ray origin, direction and
// epsilon are written through cfg; the user must write them only while the
// block is idle, the block itself does not enforce it. One triangle beat
// is taken, then triangle.ready stays low while the test runs on one shared
// 32x32 multiplier (30 products, one per cycle), a bit-serial divider for t
// and a bit-serial square root for the distance. A triangle rejected by the
// determinant or barycentric test skips the divider, and one rejected on t
// skips the hit-point products and the square root. One result beat leaves
// after the triangle marked last_tri; if the previous result is still unread
// the block holds until it is taken.
module ray_triangle_closest_hit (
	input logic clk,
	input logic arst_n,
	rtc_tri_if.sink triangle,
	rtc_hit_if.source result,
	rtc_cfg_if.sink cfg
);
	import rtc_pkg::*;

	state_t state_q, state_d;

	vec3_t org_q, dir_q;
	logic [EpsW-1:0] eps_q;

	vec3_t e1_q, e2_q, s_q, h_q, q_q, pt_q, m_q;
	logic last_q;
	logic signed [CoordW-1:0] det_q;
	logic signed [AccW-1:0] un_q, vn_q, tn_q, acc_q;
	logic [ProdW-1:0] sum_q;
	logic [QuoW-1:0] t_q;
	logic [PcW-1:0] pc_q;

	logic vld_s1;
	step_t ctl_s1;
	step_t step;

	logic [CoordW-1:0] best_dist_q;
	vec3_t best_pt_q;
	logic seen_q;

	logic out_vld_q, out_hit_q;
	vec3_t out_pt_q;
	logic [DistW-1:0] out_dist_q;

	logic tri_acc, issue, div_start, sq_start, emit, can_emit;
	logic signed [CoordW-1:0] op_a, op_b;
	logic signed [ProdW-1:0] prod;
	logic signed [AccW-1:0] pq, term, acc_n;
	logic signed [CoordW-1:0] ptv, mv, org_c;
	logic [ProdW-1:0] sum_n;

	logic [CoordW-1:0] absdet;
	logic signed [AccW-1:0] unp, vnp, tnp, dd;
	logic pass;

	logic div_done, sq_done;
	logic [QuoW-1:0] quot;
	logic [RootW-1:0] root;
	logic [DistW-1:0] root_sat;

	assign tri_acc = triangle.valid && triangle.ready;
	assign can_emit = !out_vld_q || result.ready;
	assign step = step_f(pc_q);

	function automatic logic signed [CoordW-1:0] pick(input vsel_t v, input logic [1:0] i);
		logic signed [CoordW-1:0] r;
		unique case (v)
			V_D:  r = comp(dir_q, i);
			V_E1: r = comp(e1_q, i);
			V_E2: r = comp(e2_q, i);
			V_S:  r = comp(s_q, i);
			V_H:  r = comp(h_q, i);
			V_Q:  r = comp(q_q, i);
			V_T:  r = {1'b0, t_q};
			V_M:  r = comp(m_q, i);
			default: r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		op_a = pick(step.va, step.ia);
		op_b = pick(step.vb, step.ib);
	end

	rtc_mul mul_i (.clk(clk), .a(op_a), .b(op_b), .prod(prod));

	// Product floored to Q36.16, then accumulate or write back; the squared offsets sum the full product.
	always_comb begin
		pq = AccW'(prod >>> 16);
		term = ctl_s1.neg ? -pq : pq;
		acc_n = (ctl_s1.first ? '0 : acc_q) + term;
		org_c = comp(org_q, ctl_s1.wi);
		ptv = sat32(AccW'(org_c) + pq);
		mv = sat32(AccW'(ptv) - AccW'(org_c));
		sum_n = (ctl_s1.first ? '0 : sum_q) + ProdW'(prod);
	end

	// Orient by the sign of the determinant, then the range tests.
	always_comb begin
		absdet = det_q[CoordW-1] ? CoordW'(-det_q) : CoordW'(det_q);
		unp = det_q[CoordW-1] ? -un_q : un_q;
		vnp = det_q[CoordW-1] ? -vn_q : vn_q;
		tnp = det_q[CoordW-1] ? -tn_q : tn_q;
		dd = AccW'({1'b0, absdet});
		pass = (absdet > CoordW'(eps_q)) && !unp[AccW-1] && !(unp > dd)
			&& !vnp[AccW-1] && !((unp + vnp) > dd) && (tnp > 0);
	end

	rtc_div div_i (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(tnp[DivNW-1:0]), .divisor(absdet),
		.done(div_done), .quot(quot)
	);

	rtc_sqrt sqrt_i (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.radicand(sum_n), .done(sq_done), .root(root)
	);

	assign root_sat = root[RootW-1] ? MaxQ[DistW-1:0] : root[DistW-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (tri_acc) state_d = ST_MACA;
			ST_MACA:   if (pc_q == LastStepA) state_d = ST_DRAINA;
			ST_DRAINA: state_d = ST_CHECK;
			ST_CHECK:  state_d = pass ? ST_DIV : ST_FINISH;
			ST_DIV:    if (div_done) state_d = ST_TCHK;
			ST_TCHK:   state_d = (t_q > QuoW'(eps_q)) ? ST_MACB : ST_FINISH;
			ST_MACB:   if (pc_q == LastStepB) state_d = ST_DRAINB;
			ST_DRAINB: state_d = ST_SQRT;
			ST_SQRT:   if (sq_done) state_d = ST_FINISH;
			ST_FINISH: if (!last_q || can_emit) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		triangle.ready = state_q == ST_IDLE;
		issue = (state_q == ST_MACA) || (state_q == ST_MACB);
		div_start = (state_q == ST_CHECK) && pass;
		sq_start = state_q == ST_DRAINB;
		emit = (state_q == ST_FINISH) && last_q && can_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			vld_s1 <= 1'b0;
			org_q <= '0;
			dir_q <= '{x: '0, y: '0, z: OneQ};
			eps_q <= EpsW'(1);
			best_dist_q <= '1;
			best_pt_q <= '0;
			seen_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= issue;
			if (tri_acc)
				pc_q <= '0;
			else if (issue)
				pc_q <= pc_q + PcW'(1);
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_ORIGIN_X: org_q.x <= cfg.data;
					REG_ORIGIN_Y: org_q.y <= cfg.data;
					REG_ORIGIN_Z: org_q.z <= cfg.data;
					REG_DIR_X:    dir_q.x <= cfg.data;
					REG_DIR_Y:    dir_q.y <= cfg.data;
					REG_DIR_Z:    dir_q.z <= cfg.data;
					REG_EPSILON:  eps_q <= cfg.data[EpsW-1:0];
					default: ;
				endcase
			end
			// Equal distance keeps the earlier triangle.
			if (state_q == ST_SQRT && sq_done) begin
				seen_q <= 1'b1;
				if ({1'b0, root_sat} < best_dist_q) begin
					best_dist_q <= {1'b0, root_sat};
					best_pt_q <= pt_q;
				end
			end
			if (emit) begin
				out_vld_q <= 1'b1;
				best_dist_q <= '1;
				best_pt_q <= '0;
				seen_q <= 1'b0;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tri_acc) begin
			e1_q.x <= sat32(AccW'(triangle.b_x) - AccW'(triangle.a_x));
			e1_q.y <= sat32(AccW'(triangle.b_y) - AccW'(triangle.a_y));
			e1_q.z <= sat32(AccW'(triangle.b_z) - AccW'(triangle.a_z));
			e2_q.x <= sat32(AccW'(triangle.c_x) - AccW'(triangle.a_x));
			e2_q.y <= sat32(AccW'(triangle.c_y) - AccW'(triangle.a_y));
			e2_q.z <= sat32(AccW'(triangle.c_z) - AccW'(triangle.a_z));
			s_q.x <= sat32(AccW'(org_q.x) - AccW'(triangle.a_x));
			s_q.y <= sat32(AccW'(org_q.y) - AccW'(triangle.a_y));
			s_q.z <= sat32(AccW'(org_q.z) - AccW'(triangle.a_z));
			last_q <= triangle.last_tri;
		end
		if (issue)
			ctl_s1 <= step;
		if (vld_s1) begin
			acc_q <= acc_n;
			unique case (ctl_s1.wb)
				WB_NONE: ;
				WB_H:    h_q <= put(h_q, ctl_s1.wi, sat32(acc_n));
				WB_Q:    q_q <= put(q_q, ctl_s1.wi, sat32(acc_n));
				WB_DET:  det_q <= sat32(acc_n);
				WB_UN:   un_q <= acc_n;
				WB_VN:   vn_q <= acc_n;
				WB_TN:   tn_q <= acc_n;
				WB_PT: begin
					pt_q <= put(pt_q, ctl_s1.wi, ptv);
					m_q <= put(m_q, ctl_s1.wi, mv);
				end
				WB_SQ:   sum_q <= sum_n;
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_done)
			t_q <= quot;
		if (emit) begin
			out_hit_q <= seen_q;
			out_pt_q <= seen_q ? best_pt_q : '0;
			out_dist_q <= seen_q ? best_dist_q[DistW-1:0] : '0;
		end
	end

	assign cfg.ready = 1'b1;
	assign result.valid = out_vld_q;
	assign result.any_hit = out_hit_q;
	assign result.hit_x = out_pt_q.x;
	assign result.hit_y = out_pt_q.y;
	assign result.hit_z = out_pt_q.z;
	assign result.hit_distance = out_dist_q;
endmodule

/* hw/rtl/rtc_chk.sv */
`include "ray_triangle_closest_hit_defines.svh"

module rtc_chk (
	input logic clk,
	input logic arst_n,
	input logic tri_valid,
	input logic tri_ready,
	input logic res_valid,
	input logic res_ready,
	input logic any_hit,
	input logic [31:0] hit_x,
	input logic [31:0] hit_y,
	input logic [31:0] hit_z,
	input logic [30:0] hit_distance
);
	// A triangle beat keeps the block busy for the following cycle.
	`RTC_ASSERT_NEXT(a_busy_after_tri, tri_valid && tri_ready, !tri_ready, "ready right after tri beat")

	// A new result is only produced while no triangle can be taken.
	`RTC_ASSERT(a_emit_while_busy, $rose(res_valid) |-> !$past(tri_ready), "result rose while idle")

	// A mesh with no hit reports all zeros.
	`RTC_ASSERT(a_miss_zero, res_valid && !any_hit |-> hit_x == 0 && hit_y == 0 && hit_z == 0 && hit_distance == 0, "miss fields not zero")

	// Hold a stalled result.
	`RTC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(any_hit) && $stable(hit_x) && $stable(hit_y) && $stable(hit_z) && $stable(hit_distance), "stalled result changed")
endmodule

bind ray_triangle_closest_hit rtc_chk chk_i (
	.clk(clk),
	.arst_n(arst_n),
	.tri_valid(triangle.valid),
	.tri_ready(triangle.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.any_hit(result.any_hit),
	.hit_x(result.hit_x),
	.hit_y(result.hit_y),
	.hit_z(result.hit_z),
	.hit_distance(result.hit_distance)
);
